// File: rtl/core/prb_pkg.sv
// ----------------------------------------------------------------------------
// prb_pkg
// Shared result codes and the result word layout of the reorder buffer.
// ----------------------------------------------------------------------------
package prb_pkg;

	localparam int SEQ_BITS  = 6;
	localparam int WORD_BITS = 64;

	// input commands; CMD_NONE is not a valid command and is ignored
	typedef enum logic [1:0] {
		CMD_DATA  = 2'd0,
		CMD_CLOSE = 2'd1,
		CMD_TICK  = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	// result kinds
	typedef enum logic [2:0] {
		KIND_ACK         = 3'd0,
		KIND_DELIVER     = 3'd1,
		KIND_CLOSE_ACK   = 3'd2,
		KIND_TIMEOUT_END = 3'd3,
		KIND_REJECT      = 3'd4
	} kind_t;

	// one result word
	typedef struct packed {
		kind_t                 kind;
		logic [SEQ_BITS-1:0]   seq;
		logic [WORD_BITS-1:0]  data;
		logic                  last;
	} res_t;

endpackage

// File: rtl/core/prb_store.sv
// ----------------------------------------------------------------------------
// prb_store
// Payload memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module prb_store #(
	parameter int DEPTH = 32,
	parameter int WIDTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read port, data holds until the next read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// File: rtl/core/prb_out_reg.sv
// ----------------------------------------------------------------------------
// prb_out_reg
// Output register for result words; frees itself when the word is taken.
// ----------------------------------------------------------------------------
module prb_out_reg (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          load,
	input  prb_pkg::res_t din,
	output logic          free,
	output logic          res_valid,
	input  logic          res_stall,
	output prb_pkg::res_t dout
);

	import prb_pkg::*;

	logic valid_q;
	res_t res_q;

	// occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!res_stall) begin
			valid_q <= 1'b0;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= din;
		end
	end

	assign free      = !valid_q || !res_stall;
	assign res_valid = valid_q;
	assign dout      = res_q;

endmodule

// File: rtl/core/packet_reorder_buffer.sv
// ----------------------------------------------------------------------------
// packet_reorder_buffer
// Selective-repeat receiver: stores packets by sequence number, acks new
// ones and delivers the contiguous run from the next expected number.
// ----------------------------------------------------------------------------
//  channel   handshake             word
//  pkt       pkt_valid/pkt_stall   cmd, seq_number, payload
//  res       res_valid/res_stall   kind, seq_out, data_out, last
//  cfg       cfg_wr_en             cfg_wr_data (max_timeouts)
//
// An item is taken when pkt_valid is high and pkt_stall is low; ack, reject,
// close ack and timeout end leave on the next edge. A run of deliveries passes
// ST_RD (payload memory read), then ST_DLV: one word per cycle unless stalled.
// Reset clears the received map flip-flops at once; no clearing pass.
// res_stall holds the output register, input and ST_DLV; ST_RD moves on.
// ----------------------------------------------------------------------------
module packet_reorder_buffer #(
	parameter int SEQ_SPACE    = 32,
	parameter int PAYLOAD_BITS = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           pkt_valid,
	output logic                           pkt_stall,
	input  logic [1:0]                     cmd,
	input  logic [prb_pkg::SEQ_BITS-1:0]   seq_number,
	input  logic [prb_pkg::WORD_BITS-1:0]  payload,
	output logic                           res_valid,
	input  logic                           res_stall,
	output logic [2:0]                     kind,
	output logic [prb_pkg::SEQ_BITS-1:0]   seq_out,
	output logic [prb_pkg::WORD_BITS-1:0]  data_out,
	output logic                           last,
	input  logic                           cfg_wr_en,
	input  logic [3:0]                     cfg_wr_data
);

	import prb_pkg::*;

	localparam int IDX_W = $clog2(SEQ_SPACE);
	localparam int NE_W  = $clog2(SEQ_SPACE + 1);
	localparam logic [NE_W-1:0]     NE_END  = NE_W'(SEQ_SPACE);
	localparam logic [SEQ_BITS-1:0] SEQ_END = SEQ_BITS'(SEQ_SPACE);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RD,
		ST_DLV
	} state_t;

	state_t                state_q;
	logic [SEQ_SPACE-1:0]  map_q;
	logic [NE_W-1:0]       ne_q;
	logic [3:0]            tc_q;
	logic [3:0]            max_q;
	logic                  done_q;

	logic                  acc;
	logic                  out_free;
	logic                  out_load;
	res_t                  out_din;
	res_t                  out_dout;

	logic [IDX_W-1:0]      seq_idx;
	logic [IDX_W-1:0]      ne_idx;
	logic [NE_W-1:0]       ne_inc;
	logic [IDX_W-1:0]      ne_inc_idx;
	logic                  seq_ok;
	logic                  slot_full;
	logic [SEQ_SPACE-1:0]  map_set;
	logic                  ne_hit;
	logic                  more;
	logic [3:0]            tc_nx;
	logic                  to_end;
	logic                  store_wr;
	logic                  rd_en;
	logic [IDX_W-1:0]      rd_addr;
	logic [PAYLOAD_BITS-1:0] rd_data;

	// input handshake
	assign pkt_stall = (state_q != ST_IDLE) || !out_free;
	assign acc       = pkt_valid && !pkt_stall;

	// index and lookahead
	assign seq_idx    = seq_number[IDX_W-1:0];
	assign ne_idx     = ne_q[IDX_W-1:0];
	assign ne_inc     = ne_q + NE_W'(1);
	assign ne_inc_idx = ne_inc[IDX_W-1:0];
	assign seq_ok     = seq_number < SEQ_END;
	assign slot_full  = map_q[seq_idx];
	assign map_set    = map_q | (SEQ_SPACE'(1) << seq_idx);
	assign ne_hit     = (ne_q < NE_END) ? map_set[ne_idx] : 1'b0;
	assign more       = (ne_inc < NE_END) ? map_q[ne_inc_idx] : 1'b0;
	assign tc_nx      = (tc_q != 4'hF) ? tc_q + 4'd1 : tc_q;
	assign to_end     = tc_nx >= max_q;

	assign store_wr = acc && !done_q && (cmd == CMD_DATA) && seq_ok && !slot_full;

	// result word and output load
	always_comb begin
		out_din  = '{kind: KIND_ACK, seq: '0, data: '0, last: 1'b1};
		out_load = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (acc && !done_q) begin
					priority if (cmd == CMD_DATA) begin
						if (!seq_ok) begin
							out_din.kind = KIND_REJECT;
							out_din.seq  = seq_number;
							out_load     = 1'b1;
						end else if (!slot_full) begin
							out_din.kind = KIND_ACK;
							out_din.seq  = seq_number;
							out_din.last = !ne_hit;
							out_load     = 1'b1;
						end
					end else if (cmd == CMD_CLOSE) begin
						out_din.kind = KIND_CLOSE_ACK;
						out_load     = 1'b1;
					end else if (cmd == CMD_TICK) begin
						out_din.kind = KIND_TIMEOUT_END;
						out_load     = to_end;
					end else begin
						out_load = 1'b0;
					end
				end
			end
			ST_RD: begin
				out_load = 1'b0;
			end
			ST_DLV: begin
				out_din.kind = KIND_DELIVER;
				out_din.seq  = SEQ_BITS'(ne_q);
				out_din.data = WORD_BITS'(rd_data);
				out_din.last = !more;
				out_load     = out_free;
			end
			default: begin
				out_load = 1'b0;
			end
		endcase
	end

	// memory read: first word from ST_RD, following words chained in ST_DLV
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = ne_idx;
		unique case (state_q)
			ST_RD: begin
				rd_en = 1'b1;
			end
			ST_DLV: begin
				rd_en   = out_free && more;
				rd_addr = ne_inc_idx;
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	// sequencer and session state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			map_q   <= '0;
			ne_q    <= '0;
			tc_q    <= '0;
			max_q   <= 4'd3;
			done_q  <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				max_q <= cfg_wr_data;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (acc && !done_q) begin
						priority if (cmd == CMD_DATA) begin
							if (store_wr) begin
								map_q <= map_set;
								if (ne_hit) begin
									state_q <= ST_RD;
								end
							end
						end else if (cmd == CMD_CLOSE) begin
							done_q <= 1'b1;
						end else if (cmd == CMD_TICK) begin
							tc_q <= tc_nx;
							if (to_end) begin
								done_q <= 1'b1;
							end
						end else begin
							done_q <= done_q;
						end
					end
				end
				ST_RD: begin
					state_q <= ST_DLV;
				end
				ST_DLV: begin
					if (out_free) begin
						ne_q    <= ne_inc;
						state_q <= more ? ST_DLV : ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	prb_store #(
		.DEPTH (SEQ_SPACE),
		.WIDTH (PAYLOAD_BITS)
	) u_store (
		.clk     (clk),
		.wr_en   (store_wr),
		.wr_addr (seq_idx),
		.wr_data (payload[PAYLOAD_BITS-1:0]),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	prb_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (out_load),
		.din       (out_din),
		.free      (out_free),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.dout      (out_dout)
	);

	assign kind     = out_dout.kind;
	assign seq_out  = out_dout.seq;
	assign data_out = out_dout.data;
	assign last     = out_dout.last;

endmodule
